>>> hw/rtl/shp_pkg.sv
// shared constants and types of the 3x3 sharpening stencil
`default_nettype none

package shp_pkg;

  // sample and configuration widths
  localparam int SAMPLE_W   = 8;
  localparam int LANES      = 4;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CHAN_W     = 3;
  localparam int ROW_W      = 11;

  // frame limits and filter gain
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 2048;
  localparam int GAIN       = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_USED = 2'd2;

  // request kinds on the pixel channel
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // one result as held in the output queue
  typedef struct packed {
    sample_t out3;
    sample_t out2;
    sample_t out1;
    sample_t out0;
    logic    frame_end;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/shp_ifs.sv
// pixel and result channel interfaces of the sharpening stencil
`default_nettype none

// incoming pixel or flush requests
interface shp_pixel_if;
  logic             valid;
  logic             ready;
  logic             action;
  shp_pkg::sample_t sample0;
  shp_pkg::sample_t sample1;
  shp_pkg::sample_t sample2;
  shp_pkg::sample_t sample3;

  modport source (output valid, action, sample0, sample1, sample2, sample3, input ready);
  modport sink   (input valid, action, sample0, sample1, sample2, sample3, output ready);
endinterface

// outgoing sharpened pixels
interface shp_result_if;
  logic             valid;
  logic             ready;
  shp_pkg::sample_t out0;
  shp_pkg::sample_t out1;
  shp_pkg::sample_t out2;
  shp_pkg::sample_t out3;
  logic             frame_end;

  modport source (output valid, out0, out1, out2, out3, frame_end, input ready);
  modport sink   (input valid, out0, out1, out2, out3, frame_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sharpen_3x3_stencil.sv
// top level of the streaming 3x3 laplacian sharpening stencil
//
// Takes one pixel request per clock in raster order and gives, per used channel,
// 5*centre minus the four direct neighbours saturated to 0..255, with the first and
// last rows and columns forced to zero. A result belongs to the centre that entered
// one row plus one pixel earlier; flush requests after the frame drain the results
// still owed. Each request passes three steps in the pipe (line store read, window
// shift, arithmetic into a four-entry output queue). The rate is one request per
// cycle, set by one read and one write of each line store per request; input ready
// drops only when every slot of the output queue is reserved for a result. The line
// stores are not swept at reset: anything they hold before a frame's own rows reach
// them only feeds border pixels, which are zero. A write to a mapped register
// restarts the frame position and drops owed results; the user is to write registers
// only while the block is idle, which the block itself does not enforce.
`default_nettype none

module sharpen_3x3_stencil #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shp_pkg::CFG_W-1:0]      cfg_data,
  shp_pixel_if.sink                      in_ch,
  shp_result_if.source                   out_ch
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int SW  = shp_pkg::SAMPLE_W;
  localparam int PW  = SW * MAX_CHANNELS;
  localparam int RW  = shp_pkg::ROW_W;
  localparam int NW  = shp_pkg::CHAN_W;
  localparam int FD  = 4;
  localparam int FAW = $clog2(FD);
  localparam int KW  = $clog2(FD + 1);

  // configuration registers
  logic [shp_pkg::CFG_W-1:0] image_width;
  logic [shp_pkg::CFG_W-1:0] image_height;
  logic [NW-1:0]             channels_used;

  // effective frame geometry
  logic [WW-1:0]             w_eff;
  logic [shp_pkg::CFG_W-1:0] h_eff;
  logic [NW-1:0]             n_eff;
  logic [CW-1:0]             col_last;
  logic [RW-1:0]             row_last;
  logic [WW-1:0]             owed_full;

  // stream position and owed results
  logic [CW-1:0] in_column;
  logic [RW-1:0] in_row;
  logic [CW-1:0] out_column;
  logic [RW-1:0] out_row;
  logic [WW-1:0] owed_cnt;
  logic [KW-1:0] res_credits;

  // request decode
  logic [shp_pkg::LANES-1:0][SW-1:0] smp;
  logic [PW-1:0]                     px;
  logic                              in_req;
  logic                              is_flush;
  logic                              flush_emit;
  logic                              pix_emit;
  logic                              emit;
  logic                              take_emit;
  logic                              border;
  logic                              fend;
  logic                              cfg_hit;
  logic [shp_pkg::LANES-1:0]         lane_on;

  // first stage
  logic                      a_valid;
  logic                      a_act;
  logic [PW-1:0]             a_px;
  logic [CW-1:0]             a_col;
  logic                      a_emit;
  logic [shp_pkg::LANES-1:0] a_lanes;
  logic                      a_fend;
  logic [PW-1:0]             q_up;
  logic [PW-1:0]             q_md;

  // line stores
  logic [PW-1:0] line_upper  [MAX_WIDTH];
  logic [PW-1:0] line_middle [MAX_WIDTH];

  // window, only the taps the stencil reads
  logic [PW-1:0] win_t1, win_t2;
  logic [PW-1:0] win_m0, win_m1, win_m2;
  logic [PW-1:0] win_b1, win_b2;

  // second stage
  logic                      b_valid;
  logic [shp_pkg::LANES-1:0] b_lanes;
  logic                      b_fend;

  // arithmetic and output queue
  logic [shp_pkg::LANES-1:0][SW-1:0] lane_val;
  shp_pkg::result_t                  res;
  shp_pkg::result_t                  fifo_mem [FD];
  logic [FAW:0]                      wr_ptr;
  logic [FAW:0]                      rd_ptr;
  logic                              pop;
  logic                              fifo_full;

  // clamp the registers to their working ranges
  always_comb begin
    if (image_width < shp_pkg::CFG_W'(shp_pkg::MIN_DIM)) begin
      w_eff = WW'(shp_pkg::MIN_DIM);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height < shp_pkg::CFG_W'(shp_pkg::MIN_DIM)) begin
      h_eff = shp_pkg::CFG_W'(shp_pkg::MIN_DIM);
    end else if (image_height > shp_pkg::CFG_W'(shp_pkg::MAX_HEIGHT)) begin
      h_eff = shp_pkg::CFG_W'(shp_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    if (channels_used == '0) begin
      n_eff = NW'(1);
    end else if (32'(channels_used) > 32'(MAX_CHANNELS)) begin
      n_eff = NW'(MAX_CHANNELS);
    end else begin
      n_eff = channels_used;
    end
    col_last  = CW'(w_eff - 1'b1);
    row_last  = RW'(h_eff - 1'b1);
    owed_full = w_eff + 1'b1;
  end

  // decode of the incoming request
  assign smp = {in_ch.sample3, in_ch.sample2, in_ch.sample1, in_ch.sample0};
  assign in_ch.ready = (res_credits != KW'(FD));
  assign in_req      = in_ch.valid && in_ch.ready;
  assign is_flush    = (in_ch.action == shp_pkg::ACT_FLUSH);
  assign flush_emit  = (in_column == '0) && (in_row == '0) && (owed_cnt != '0);
  assign pix_emit    = (owed_cnt == owed_full);
  assign emit        = is_flush ? flush_emit : pix_emit;
  assign take_emit   = in_req && emit;
  assign border      = (out_row == '0) || (out_row == row_last) ||
                       (out_column == '0) || (out_column == col_last);
  assign fend        = (out_row == row_last) && (out_column == col_last);
  assign cfg_hit     = cfg_we && ((cfg_index == shp_pkg::REG_IMAGE_WIDTH) ||
                                  (cfg_index == shp_pkg::REG_IMAGE_HEIGHT) ||
                                  (cfg_index == shp_pkg::REG_CHANNELS_USED));

  // pack used channels, clear the rest
  always_comb begin
    px = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (NW'(k) < n_eff) begin
        px[k*SW +: SW] = smp[k];
      end
    end
    for (int k = 0; k < shp_pkg::LANES; k++) begin
      lane_on[k] = !border && (NW'(k) < n_eff);
    end
  end

  // output queue handshake
  assign pop       = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (wr_ptr != rd_ptr);
  assign fifo_full = (wr_ptr[FAW] != rd_ptr[FAW]) && (wr_ptr[FAW-1:0] == rd_ptr[FAW-1:0]);

  // control state, positions and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= shp_pkg::CFG_W'(640);
      image_height  <= shp_pkg::CFG_W'(480);
      channels_used <= NW'(3);
      in_column     <= '0;
      in_row        <= '0;
      out_column    <= '0;
      out_row       <= '0;
      owed_cnt      <= '0;
      res_credits   <= '0;
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          shp_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
          shp_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
          shp_pkg::REG_CHANNELS_USED: channels_used <= cfg_data[NW-1:0];
          default: ;
        endcase
      end

      if (cfg_hit) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
        owed_cnt   <= '0;
      end else if (in_req) begin
        // input position and owed count
        if (is_flush) begin
          if (flush_emit) begin
            owed_cnt <= owed_cnt - 1'b1;
          end
        end else begin
          if (in_column == col_last) begin
            in_column <= '0;
            in_row    <= (in_row == row_last) ? '0 : in_row + 1'b1;
          end else begin
            in_column <= in_column + 1'b1;
          end
          if (!pix_emit) begin
            owed_cnt <= owed_cnt + 1'b1;
          end
        end
        // output position
        if (emit) begin
          if (out_column == col_last) begin
            out_column <= '0;
            out_row    <= (out_row == row_last) ? '0 : out_row + 1'b1;
          end else begin
            out_column <= out_column + 1'b1;
          end
        end
      end

      // queue slots reserved from request to pop
      case ({take_emit, pop})
        2'b10:   res_credits <= res_credits + 1'b1;
        2'b01:   res_credits <= res_credits - 1'b1;
        default: ;
      endcase

      a_valid <= in_req;
      b_valid <= a_valid && a_emit;
      if (b_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // first stage payload
  always_ff @(posedge clk) begin
    if (in_req) begin
      a_act   <= in_ch.action;
      a_px    <= px;
      a_col   <= in_column;
      a_emit  <= emit;
      a_lanes <= lane_on;
      a_fend  <= fend;
    end
  end

  // line stores: read at request, write back in the next cycle
  always_ff @(posedge clk) begin
    if (in_req && !is_flush) begin
      q_up <= line_upper[in_column];
      q_md <= line_middle[in_column];
    end
    if (a_valid && (a_act == shp_pkg::ACT_PIXEL)) begin
      line_upper[a_col]  <= q_md;
      line_middle[a_col] <= a_px;
    end
  end

  // window shift and second stage payload
  always_ff @(posedge clk) begin
    if (a_valid && (a_act == shp_pkg::ACT_PIXEL)) begin
      win_t1 <= win_t2;
      win_t2 <= q_up;
      win_m0 <= win_m1;
      win_m1 <= win_m2;
      win_m2 <= q_md;
      win_b1 <= win_b2;
      win_b2 <= a_px;
    end
    if (a_valid) begin
      b_lanes <= a_lanes;
      b_fend  <= a_fend;
    end
  end

  // per channel stencil with saturation
  for (genvar k = 0; k < shp_pkg::LANES; k++) begin : g_lane
    if (k < MAX_CHANNELS) begin : g_used
      logic signed [11:0] acc;
      always_comb begin
        acc = $signed({4'b0, win_m1[k*SW +: SW]}) * $signed(12'(shp_pkg::GAIN))
            - $signed({4'b0, win_t1[k*SW +: SW]})
            - $signed({4'b0, win_b1[k*SW +: SW]})
            - $signed({4'b0, win_m0[k*SW +: SW]})
            - $signed({4'b0, win_m2[k*SW +: SW]});
        if (acc < 0) begin
          lane_val[k] = '0;
        end else if (acc > $signed(12'd255)) begin
          lane_val[k] = '1;
        end else begin
          lane_val[k] = acc[SW-1:0];
        end
      end
    end else begin : g_unused
      assign lane_val[k] = '0;
    end
  end

  // result word with border and unused channels cleared
  always_comb begin
    res.out0      = b_lanes[0] ? lane_val[0] : '0;
    res.out1      = b_lanes[1] ? lane_val[1] : '0;
    res.out2      = b_lanes[2] ? lane_val[2] : '0;
    res.out3      = b_lanes[3] ? lane_val[3] : '0;
    res.frame_end = b_fend;
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (b_valid) begin
      fifo_mem[wr_ptr[FAW-1:0]] <= res;
    end
  end

  assign out_ch.out0      = fifo_mem[rd_ptr[FAW-1:0]].out0;
  assign out_ch.out1      = fifo_mem[rd_ptr[FAW-1:0]].out1;
  assign out_ch.out2      = fifo_mem[rd_ptr[FAW-1:0]].out2;
  assign out_ch.out3      = fifo_mem[rd_ptr[FAW-1:0]].out3;
  assign out_ch.frame_end = fifo_mem[rd_ptr[FAW-1:0]].frame_end;

  // reserved slots never exceed the queue
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    res_credits <= KW'(FD))
    else $error("result slots over-reserved");

  // a waiting result always holds a reservation
  a_valid_has_credit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (res_credits != '0))
    else $error("result shown without a reserved slot");

  // a finished result always finds room
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> !fifo_full)
    else $error("output queue overflow");

  // owed results stay within one row plus one pixel
  a_owed_bound: assert property (@(posedge clk) disable iff (rst)
    owed_cnt <= owed_full)
    else $error("owed result count out of range");

endmodule

`default_nettype wire

>>> tb/sv/sharpen_3x3_check.sv
// result checker of the 3x3 sharpening stencil: predicts every result and compares it
`timescale 1ns / 1ps

module sharpen_3x3_check #(
  parameter int LINE_DEPTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [shp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shp_pkg::CFG_W-1:0]     cfg_data,
  shp_pixel_if                          in_ch,
  shp_result_if                         out_ch,
  output int                            fail_count,
  output int                            owed
);

  localparam int PIXEL_W        = shp_pkg::SAMPLE_W * shp_pkg::LANES;
  localparam int SAMPLE_MAX     = (1 << shp_pkg::SAMPLE_W) - 1;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int RESET_CHANNELS = 3;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // predicted block state
  logic [shp_pkg::CFG_W-1:0]  width_reg;
  logic [shp_pkg::CFG_W-1:0]  height_reg;
  logic [shp_pkg::CHAN_W-1:0] chan_reg;
  pixel_t                     upper_row [LINE_DEPTH];
  pixel_t                     middle_row [LINE_DEPTH];
  pixel_t                     window [9];
  int unsigned                in_col;
  int unsigned                in_row;
  int unsigned                out_col;
  int unsigned                out_row;
  shp_pkg::result_t           expected_pixels [$];

  function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                              int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int lane_of(pixel_t px, int k);
    return int'(px[k*shp_pkg::SAMPLE_W +: shp_pkg::SAMPLE_W]);
  endfunction

  // distance in raster positions from the next result to the next input
  function automatic int unsigned owed_count(int unsigned w, int unsigned h);
    int unsigned total;
    int unsigned in_pos;
    int unsigned out_pos;
    total   = w * h;
    in_pos  = (in_row * w + in_col) % total;
    out_pos = (out_row * w + out_col) % total;
    return (in_pos + total - out_pos) % total;
  endfunction

  // sharpen the window centre and advance the output position
  task automatic push_centre(int unsigned w, int unsigned h);
    shp_pkg::result_t             r;
    logic [shp_pkg::SAMPLE_W-1:0] lane [shp_pkg::LANES];
    int unsigned                  nch;
    int                           s;
    bit                           border;
    nch    = clamp_range(32'(chan_reg), 1, shp_pkg::LANES);
    border = out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1;
    for (int k = 0; k < shp_pkg::LANES; k++) begin
      s = 0;
      if (!border && k < nch) begin
        s = shp_pkg::GAIN * lane_of(window[4], k) - lane_of(window[1], k)
            - lane_of(window[7], k) - lane_of(window[3], k) - lane_of(window[5], k);
        if (s < 0) s = 0;
        if (s > SAMPLE_MAX) s = SAMPLE_MAX;
      end
      lane[k] = s[shp_pkg::SAMPLE_W-1:0];
    end
    r.out0      = lane[0];
    r.out1      = lane[1];
    r.out2      = lane[2];
    r.out3      = lane[3];
    r.frame_end = out_row == h - 1 && out_col == w - 1;
    expected_pixels.push_back(r);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
  endtask

  // one accepted request: pixel shift-in or flush tick
  task automatic accept_request(logic act, pixel_t raw);
    int unsigned w;
    int unsigned h;
    int unsigned nch;
    int unsigned c;
    pixel_t      px;
    pixel_t      up;
    pixel_t      md;
    w   = clamp_range(32'(width_reg), shp_pkg::MIN_DIM, LINE_DEPTH);
    h   = clamp_range(32'(height_reg), shp_pkg::MIN_DIM, shp_pkg::MAX_HEIGHT);
    nch = clamp_range(32'(chan_reg), 1, shp_pkg::LANES);
    if (act == shp_pkg::ACT_FLUSH) begin
      // only drains at a frame boundary with results still owed
      if (in_col == 0 && in_row == 0 && owed_count(w, h) != 0) push_centre(w, h);
    end else begin
      px = '0;
      for (int k = 0; k < nch; k++) begin
        px[k*shp_pkg::SAMPLE_W +: shp_pkg::SAMPLE_W] =
            raw[k*shp_pkg::SAMPLE_W +: shp_pkg::SAMPLE_W];
      end
      c  = in_col;
      up = upper_row[c];
      md = middle_row[c];
      upper_row[c]  = md;
      middle_row[c] = px;
      for (int r = 0; r < 3; r++) begin
        window[r*3]   = window[r*3+1];
        window[r*3+1] = window[r*3+2];
      end
      window[2] = up;
      window[5] = md;
      window[8] = px;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      if (owed_count(w, h) >= w + 2) push_centre(w, h);
    end
  endtask

  // a mapped register write restarts the frame position, stores keep their contents
  task automatic apply_register(logic [shp_pkg::CFG_IDX_W-1:0] idx,
                                logic [shp_pkg::CFG_W-1:0] val);
    case (idx)
      shp_pkg::REG_IMAGE_WIDTH:   width_reg = val;
      shp_pkg::REG_IMAGE_HEIGHT:  height_reg = val;
      shp_pkg::REG_CHANNELS_USED: chan_reg = val[shp_pkg::CHAN_W-1:0];
      default:                    return;
    endcase
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic compare_field(string field, logic [shp_pkg::SAMPLE_W-1:0] want,
                               logic [shp_pkg::SAMPLE_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    shp_pkg::result_t want;
    if (expected_pixels.size() == 0) begin
      $error("result with nothing expected: out0 %0d out1 %0d out2 %0d out3 %0d frame_end %0d",
             out_ch.out0, out_ch.out1, out_ch.out2, out_ch.out3, out_ch.frame_end);
      fail_count++;
    end else begin
      want = expected_pixels.pop_front();
      compare_field("out0", want.out0, out_ch.out0);
      compare_field("out1", want.out1, out_ch.out1);
      compare_field("out2", want.out2, out_ch.out2);
      compare_field("out3", want.out3, out_ch.out3);
      compare_field("frame_end", {7'd0, want.frame_end}, {7'd0, out_ch.frame_end});
    end
  endtask

  // results are matched before the request of the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      width_reg  = shp_pkg::CFG_W'(RESET_WIDTH);
      height_reg = shp_pkg::CFG_W'(RESET_HEIGHT);
      chan_reg   = shp_pkg::CHAN_W'(RESET_CHANNELS);
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      expected_pixels.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_we) apply_register(cfg_index, cfg_data);
      else if (in_ch.valid && in_ch.ready)
        accept_request(in_ch.action,
                       {in_ch.sample3, in_ch.sample2, in_ch.sample1, in_ch.sample0});
    end
    owed <= expected_pixels.size();
  end

endmodule

>>> tb/sv/sharpen_3x3_stencil_tb.sv
// testbench top of the 3x3 sharpening stencil: clock, stimulus, idling and verdict
`timescale 1ns / 1ps

module sharpen_3x3_stencil_tb;

  localparam int LINE_DEPTH    = 2048;
  localparam int PIXEL_W       = shp_pkg::SAMPLE_W * shp_pkg::LANES;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PIXEL_GOAL    = 150;
  localparam logic [shp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef logic [PIXEL_W-1:0] pixel_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we;
  logic [shp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [shp_pkg::CFG_W-1:0]     cfg_data;
  int                            sharpen_fails;
  int                            results_owed;
  int                            send_idle_pct = 31;
  int                            recv_idle_pct = 62;
  int                            hold_requests = 0;
  int                            cycle_count = 0;

  shp_pixel_if  pix_if ();
  shp_result_if res_if ();

  sharpen_3x3_stencil #(
    .MAX_WIDTH (LINE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (pix_if),
    .out_ch    (res_if)
  );

  sharpen_3x3_check #(
    .LINE_DEPTH (LINE_DEPTH)
  ) sharpen_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (pix_if),
    .out_ch     (res_if),
    .fail_count (sharpen_fails),
    .owed       (results_owed)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stalls plus long hold-offs on request
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  // random lanes, biased toward the sample extremes
  function automatic pixel_t pick_pixel();
    pixel_t px;
    for (int k = 0; k < shp_pkg::LANES; k++) begin
      case ($urandom_range(3))
        0:       px[k*shp_pkg::SAMPLE_W +: shp_pkg::SAMPLE_W] = '0;
        1:       px[k*shp_pkg::SAMPLE_W +: shp_pkg::SAMPLE_W] = '1;
        default: px[k*shp_pkg::SAMPLE_W +: shp_pkg::SAMPLE_W] =
                     shp_pkg::SAMPLE_W'($urandom_range(255));
      endcase
    end
    return px;
  endfunction

  // register value for a wanted frame size, out of range at times where it clamps
  function automatic logic [shp_pkg::CFG_W-1:0] raw_dim(int unsigned d, int unsigned top);
    if (d == shp_pkg::MIN_DIM && $urandom_range(2) == 0) begin
      return shp_pkg::CFG_W'($urandom_range(shp_pkg::MIN_DIM - 1));
    end
    if (d == top && $urandom_range(1) == 0) begin
      return shp_pkg::CFG_W'($urandom_range(4095, top + 1));
    end
    return shp_pkg::CFG_W'(d);
  endfunction

  // one request, with a random gap ahead of it
  task automatic send_request(logic act, pixel_t smp);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid   <= 1'b1;
    pix_if.action  <= act;
    pix_if.sample0 <= smp[0*shp_pkg::SAMPLE_W +: shp_pkg::SAMPLE_W];
    pix_if.sample1 <= smp[1*shp_pkg::SAMPLE_W +: shp_pkg::SAMPLE_W];
    pix_if.sample2 <= smp[2*shp_pkg::SAMPLE_W +: shp_pkg::SAMPLE_W];
    pix_if.sample3 <= smp[3*shp_pkg::SAMPLE_W +: shp_pkg::SAMPLE_W];
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  // pixels get a stray flush now and then
  task automatic send_burst(logic act, int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if (act == shp_pkg::ACT_PIXEL && $urandom_range(24) == 0) begin
        send_request(shp_pkg::ACT_FLUSH, pick_pixel());
      end
      send_request(act, pick_pixel());
    end
  endtask

  // wait until every expected result is out and the pipe has emptied
  task automatic settle();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [shp_pkg::CFG_IDX_W-1:0] idx,
                                logic [shp_pkg::CFG_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random small frames: back to back, drained, partly drained or cut short
  task automatic run_mode(int send_pct, int recv_pct, int unsigned goal);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    int unsigned last_count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < goal) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(40, 11)
                                   : $urandom_range(10, shp_pkg::MIN_DIM);
      h = $urandom_range(6, shp_pkg::MIN_DIM);
      write_register(shp_pkg::REG_IMAGE_WIDTH, raw_dim(w, LINE_DEPTH));
      write_register(shp_pkg::REG_IMAGE_HEIGHT, raw_dim(h, shp_pkg::MAX_HEIGHT));
      write_register(shp_pkg::REG_CHANNELS_USED, shp_pkg::CFG_W'($urandom_range(7)));
      if ($urandom_range(7) == 0) begin
        write_register(REG_UNMAPPED, shp_pkg::CFG_W'($urandom_range(4095)));
      end
      frames = $urandom_range(3, 1);
      repeat (frames - 1) send_burst(shp_pkg::ACT_PIXEL, w * h);
      if ($urandom_range(4) == 0) begin
        last_count = $urandom_range(w * h - 1, 1);
        send_burst(shp_pkg::ACT_PIXEL, last_count);
      end else begin
        last_count = w * h;
        send_burst(shp_pkg::ACT_PIXEL, last_count);
        send_burst(shp_pkg::ACT_FLUSH, ($urandom_range(7) == 0) ? $urandom_range(w)
                                                                 : w + 1 + $urandom_range(2));
      end
      sent += (frames - 1) * w * h + last_count;
    end
  endtask

  // stimulus
  initial begin
    pixel_t frame_a [9];
    pix_if.valid   <= 1'b0;
    pix_if.action  <= shp_pkg::ACT_PIXEL;
    pix_if.sample0 <= '0;
    pix_if.sample1 <= '0;
    pix_if.sample2 <= '0;
    pix_if.sample3 <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= shp_pkg::REG_IMAGE_WIDTH;
    cfg_data       <= '0;
    // lanes around the centre: clip high, clip low, flat, mixed neighbours
    frame_a = '{32'hA5A5_A5A5, 32'h0A64_FF00, 32'h5A5A_5A5A,
                32'h1E64_FF00, 32'h3C64_00FF, 32'h2864_FF00,
                32'hFFFF_FFFF, 32'h1464_FF00, 32'h0000_0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // smallest frame, flushes with nothing owed and inside the frame
    write_register(shp_pkg::REG_IMAGE_WIDTH, 12'd3);
    write_register(shp_pkg::REG_IMAGE_HEIGHT, 12'd3);
    write_register(shp_pkg::REG_CHANNELS_USED, 12'd4);
    send_request(shp_pkg::ACT_FLUSH, '1);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_request(shp_pkg::ACT_FLUSH, '0);
      send_request(shp_pkg::ACT_PIXEL, frame_a[i]);
    end
    // next frame right behind, then one flush more than owed
    for (int i = 0; i < 9; i++) send_request(shp_pkg::ACT_PIXEL, ~frame_a[i]);
    send_burst(shp_pkg::ACT_FLUSH, 5);

    run_mode(31, 62, PIXEL_GOAL);
    run_mode(62, 31, PIXEL_GOAL);

    // receiver holds off while the sender keeps offering, so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(shp_pkg::REG_IMAGE_WIDTH, 12'd8);
    write_register(shp_pkg::REG_IMAGE_HEIGHT, 12'd8);
    write_register(shp_pkg::REG_CHANNELS_USED, 12'd4);
    hold_requests++;
    send_burst(shp_pkg::ACT_PIXEL, 64);
    send_burst(shp_pkg::ACT_FLUSH, 9);

    run_mode(0, 0, PIXEL_GOAL);

    // start of the widest and the tallest frame, then an over-range width left unfinished
    write_register(shp_pkg::REG_IMAGE_WIDTH, shp_pkg::CFG_W'(LINE_DEPTH));
    write_register(shp_pkg::REG_IMAGE_HEIGHT, 12'd2);
    write_register(shp_pkg::REG_CHANNELS_USED, 12'd7);
    send_burst(shp_pkg::ACT_PIXEL, 40);
    write_register(shp_pkg::REG_IMAGE_WIDTH, 12'd1);
    write_register(shp_pkg::REG_IMAGE_HEIGHT, 12'd4095);
    write_register(shp_pkg::REG_CHANNELS_USED, 12'd5);
    send_burst(shp_pkg::ACT_PIXEL, 5 * shp_pkg::MIN_DIM);
    send_burst(shp_pkg::ACT_FLUSH, shp_pkg::MIN_DIM + 1);
    write_register(shp_pkg::REG_IMAGE_WIDTH, 12'd4095);
    write_register(shp_pkg::REG_IMAGE_HEIGHT, 12'd2049);
    write_register(shp_pkg::REG_CHANNELS_USED, 12'd0);
    send_burst(shp_pkg::ACT_PIXEL, 40);
    settle();

    if (sharpen_fails == 0 && results_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
